[rtl/pwmlls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmlls_pkg
// Shared types, constants and helper functions of the position weight
// matrix log-likelihood scorer.
// ----------------------------------------------------------------------------
package pwmlls_pkg;

  // default sizing
  localparam int unsigned MAX_MOTIF_LEN_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  // field widths
  localparam int unsigned COL_W      = 6;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned PROB_W     = 17;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned START_W    = 6;
  localparam int unsigned SCORE_W    = 27;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // integer bits of a stored -ln(p) entry
  localparam int unsigned NEGLOG_INT_W = 5;
  // fraction bits of log2 produced by the squaring loop
  localparam int unsigned LOG_FRAC_W   = 28;

  localparam logic [31:0]        LN2_Q30       = 32'd744261118;
  localparam logic [31:0]        NEGLN_EPS_Q24 = 32'd463571610;
  localparam logic [PROB_W-1:0]  PROB_ONE      = 17'd65536;
  localparam logic [LEN_W-1:0]   COUNT_MAX     = 7'd127;
  localparam logic [SCORE_W-1:0] SCORE_MAX     = 27'h7FF_FFFF;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SCORE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORE_LENGTH  = 2'd2;

  // base slots
  localparam logic [SLOT_W-1:0] SLOT_A = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_C = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_G = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_T = 2'd3;

  // ascii nucleotide codes
  localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
  localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;
  localparam logic [CHAR_W-1:0] CHAR_U_UP = 8'h55;
  localparam logic [CHAR_W-1:0] CHAR_U_LO = 8'h75;

  typedef struct packed {
    logic              operation;
    logic [COL_W-1:0]  column;
    logic [SLOT_W-1:0] base_slot;
    logic [PROB_W-1:0] probability;
    logic [CHAR_W-1:0] base_char;
    logic              last_base;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] total_score;
    logic [SCORE_W-1:0] window_score;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic              known;
    logic [SLOT_W-1:0] slot;
  } char_slot_t;

  // -ln(1e-12), rounded half up to frac fraction bits
  function automatic logic [31:0] neg_eps_q(input int unsigned frac);
    logic [31:0] r;
    r = (NEGLN_EPS_Q24 + (32'd1 << (23 - frac))) >> (24 - frac);
    return r;
  endfunction

  // -ln(0.25) = 2 * ln2, rounded half up to frac fraction bits
  function automatic logic [31:0] neg_quarter_q(input int unsigned frac);
    logic [31:0] r;
    r = (LN2_Q30 + (32'd1 << (28 - frac))) >> (29 - frac);
    return r;
  endfunction

  // nucleotide character to table slot, case ignored, u counts as t
  function automatic char_slot_t char_slot(input logic [CHAR_W-1:0] ch);
    char_slot_t r;
    case (ch) inside
      CHAR_A_UP, CHAR_A_LO: r = '{known: 1'b1, slot: SLOT_A};
      CHAR_C_UP, CHAR_C_LO: r = '{known: 1'b1, slot: SLOT_C};
      CHAR_G_UP, CHAR_G_LO: r = '{known: 1'b1, slot: SLOT_G};
      CHAR_T_UP, CHAR_T_LO,
      CHAR_U_UP, CHAR_U_LO: r = '{known: 1'b1, slot: SLOT_T};
      default:              r = '{known: 1'b0, slot: SLOT_A};
    endcase
    return r;
  endfunction

endpackage

[rtl/pwmlls_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmlls_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pwmlls_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pwmlls_neglog.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmlls_neglog
// Iterative converter from a Q1.16 probability to -ln(p) in fixed point,
// using leading-one normalization, log2 by repeated squaring and a scale by ln2.
// ----------------------------------------------------------------------------
module pwmlls_neglog
  import pwmlls_pkg::*;
#(
  parameter  int unsigned FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned NW        = NEGLOG_INT_W + FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROB_W-1:0] prob_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [NW-1:0]     result_o
);

  localparam logic [NW-1:0] NEG_EPS = NW'(neg_eps_q(FRAC_BITS));
  localparam int unsigned   ITER_W  = $clog2(LOG_FRAC_W);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(LOG_FRAC_W - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_NORM   = 3'd1;
  localparam logic [2:0] ST_SQUARE = 3'd2;
  localparam logic [2:0] ST_DIFF   = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_ROUND  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [PROB_W-1:0]     v_q, v_d;
  logic                  zero_q, zero_d;
  logic [4:0]            k_q, k_d;
  logic [31:0]           m_q, m_d;
  logic [LOG_FRAC_W-1:0] frac_q, frac_d;
  logic [ITER_W-1:0]     iter_q, iter_d;
  logic [31:0]           lo_q, lo_d;
  logic                  hi_q, hi_d;
  logic [63:0]           prod_q, prod_d;

  logic [4:0]  lead;
  logic [63:0] sq;
  logic [32:0] nl;
  logic [63:0] rnd_sum;

  // leading one of the saturated probability
  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < PROB_W; i++) begin
      if (v_q[i]) begin
        lead = 5'(i);
      end
    end
  end

  assign sq      = m_q * m_q;
  assign nl      = {(5'd16 - k_q), {LOG_FRAC_W{1'b0}}} - {5'd0, frac_q};
  assign rnd_sum = prod_q + (hi_q ? {LN2_Q30, 32'd0} : 64'd0)
                 + (64'd1 << (57 - FRAC_BITS));

  always_comb begin
    state_d = state_q;
    v_d     = v_q;
    zero_d  = zero_q;
    k_d     = k_q;
    m_d     = m_q;
    frac_d  = frac_q;
    iter_d  = iter_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    prod_d  = prod_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          v_d     = (prob_i > PROB_ONE) ? PROB_ONE : prob_i;
          zero_d  = (prob_i == '0);
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        k_d     = lead;
        m_d     = 32'(v_q) << (5'd31 - lead);
        frac_d  = '0;
        iter_d  = ITER_LAST;
        state_d = zero_q ? ST_ROUND : ST_SQUARE;
      end
      ST_SQUARE: begin
        // square stays in [1,4): a result of 2 or more yields a one bit
        if (sq[63]) begin
          m_d    = sq[63:32];
          frac_d = {frac_q[LOG_FRAC_W-2:0], 1'b1};
        end else begin
          m_d    = sq[62:31];
          frac_d = {frac_q[LOG_FRAC_W-2:0], 1'b0};
        end
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == '0) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        lo_d    = nl[31:0];
        hi_d    = nl[32];
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = lo_q * LN2_Q30;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    zero_q <= zero_d;
    k_q    <= k_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    iter_q <= iter_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    prod_q <= prod_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = (state_q == ST_ROUND);
  assign result_o = zero_q ? NEG_EPS : rnd_sum[58 - FRAC_BITS +: NW];

endmodule

[rtl/pwm_log_likelihood_scorer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_log_likelihood_scorer_core
// Position weight matrix scorer: loads -ln(p) entries, then sums them along a
// streamed sequence into a full-motif score and a core-window score.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (valid/ready): load items write one probability of one column
//   and base slot; score items carry one ascii base each, the one marked
//   last_base closes the sequence and produces one result item.
//   out channel (valid/ready): full-motif score, core-window score and the
//   length status.
//   cfg port: plain write, index 0 motif columns, 1 first core column,
//   2 core columns; write only while no item is in flight.
// Timing:
//   score items are taken one per cycle while no load converts and the read
//   stage is free; out_valid_o rises once the last base has been read from
//   the table and accumulated into the output register.
//   a load item with a column inside the table holds in_ready_o low while the
//   log unit normalizes, runs 28 squaring steps on a 32x32 multiplier,
//   subtracts, scales by ln2 and rounds; a zero probability skips to round.
// Reset:
//   clears counters, accumulators, the pipeline and the output valid and
//   restores the register defaults; the table holds nothing until loaded and
//   needs no clearing pass.
// Stall:
//   a waiting result sits in the output register; non-final bases still flow,
//   a second final base waits in the read stage until the result is taken.
// ----------------------------------------------------------------------------
module pwm_log_likelihood_scorer_core
  import pwmlls_pkg::*;
#(
  parameter int unsigned MAX_MOTIF_LEN = MAX_MOTIF_LEN_DEF,
  parameter int unsigned FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item input
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // table geometry and entry width
  localparam int unsigned NW    = NEGLOG_INT_W + FRAC_BITS;
  localparam int unsigned DEPTH = MAX_MOTIF_LEN * 4;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // sum width wide enough to detect saturation
  localparam int unsigned SW    = ((NW > SCORE_W) ? NW : SCORE_W) + 1;

  localparam logic [NW-1:0] NEG_QUARTER = NW'(neg_quarter_q(FRAC_BITS));
  localparam logic [SW-1:0] SUM_MAX     = SW'(SCORE_MAX);

  // flags carried with a base from the read stage to the accumulate stage
  typedef struct packed {
    logic in_motif;
    logic in_core;
    logic known;
    logic last;
    logic status;
  } read_stage_t;

  // configuration registers
  logic [LEN_W-1:0]   motif_cols_q;
  logic [START_W-1:0] win_first_q;
  logic [LEN_W-1:0]   win_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motif_cols_q <= LEN_W'(1);
      win_first_q  <= '0;
      win_cols_q   <= LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MOTIF_LENGTH: motif_cols_q <= cfg_wdata_i;
        CFG_CORE_START:   win_first_q  <= cfg_wdata_i[START_W-1:0];
        CFG_CORE_LENGTH:  win_cols_q   <= cfg_wdata_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // input handshake
  logic in_fire, fire_load, fire_score;
  logic conv_busy, conv_done;
  logic s1_adv;
  logic s1_valid_q, s1_valid_d;
  read_stage_t s1_q, s1_d;

  assign in_fire    = in_valid_i && in_ready_o;
  assign fire_load  = in_fire && (in_data_i.operation == OP_LOAD);
  assign fire_score = in_fire && (in_data_i.operation == OP_SCORE);

  // a new item enters while the log unit is idle and the read stage can move
  assign in_ready_o = !conv_busy && (!s1_valid_q || s1_adv);

  // load path: columns beyond the table are accepted and dropped
  logic          load_ok;
  logic          conv_start;
  logic [AW-1:0] load_addr_q;
  logic [NW-1:0] conv_result;

  assign load_ok    = (32'(in_data_i.column) < MAX_MOTIF_LEN);
  assign conv_start = fire_load && load_ok;

  always_ff @(posedge clk_i) begin
    if (conv_start) begin
      load_addr_q <= AW'({in_data_i.column, in_data_i.base_slot});
    end
  end

  pwmlls_neglog #(
    .FRAC_BITS (FRAC_BITS)
  ) u_neglog (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .prob_i   (in_data_i.probability),
    .busy_o   (conv_busy),
    .done_o   (conv_done),
    .result_o (conv_result)
  );

  // score path, read stage: position lookup and window decode
  char_slot_t    cs;
  logic [LEN_W-1:0] pos_q, pos_d, pos_inc;
  logic [AW-1:0] score_addr;
  logic [NW-1:0] table_rdata;
  logic [7:0]    win_end;
  logic          in_motif, in_core;

  assign cs         = char_slot(in_data_i.base_char);
  assign score_addr = AW'({pos_q, cs.slot});
  assign pos_inc    = (pos_q == COUNT_MAX) ? pos_q : pos_q + LEN_W'(1);
  assign win_end    = {2'b00, win_first_q} + {1'b0, win_cols_q};
  assign in_motif   = (pos_q < motif_cols_q) && (32'(pos_q) < MAX_MOTIF_LEN);
  assign in_core    = in_motif && ({1'b0, pos_q} >= {2'b00, win_first_q})
                    && ({1'b0, pos_q} < win_end);

  pwmlls_ram #(
    .WIDTH (NW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (conv_done),
    .waddr_i (load_addr_q),
    .wdata_i (conv_result),
    .re_i    (fire_score),
    .raddr_i (score_addr),
    .rdata_o (table_rdata)
  );

  always_comb begin
    pos_d = pos_q;
    s1_d  = s1_q;
    if (fire_score) begin
      // count saturates; the final base sends it back to zero
      pos_d = in_data_i.last_base ? '0 : pos_inc;
      s1_d  = '{in_motif: in_motif,
                in_core:  in_core,
                known:    cs.known,
                last:     in_data_i.last_base,
                status:   (pos_inc != motif_cols_q)};
    end
  end

  assign s1_valid_d = fire_score ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  // accumulate stage: a final base needs room in the output register
  logic [SCORE_W-1:0] full_acc_q, core_acc_q;
  logic [NW-1:0]      term;
  logic [SW-1:0]      full_sum, core_sum;
  logic [SCORE_W-1:0] full_sat, core_sat;
  logic               out_valid_q;
  out_item_t          out_q;

  assign s1_adv   = s1_valid_q && (!s1_q.last || !out_valid_q || out_ready_i);
  assign term     = s1_q.known ? table_rdata : NEG_QUARTER;
  assign full_sum = SW'(full_acc_q) + (s1_q.in_motif ? SW'(term) : '0);
  assign core_sum = SW'(core_acc_q) + (s1_q.in_core ? SW'(term) : '0);
  assign full_sat = (full_sum > SUM_MAX) ? SCORE_MAX : full_sum[SCORE_W-1:0];
  assign core_sat = (core_sum > SUM_MAX) ? SCORE_MAX : core_sum[SCORE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      s1_valid_q  <= 1'b0;
      full_acc_q  <= '0;
      core_acc_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        // a finished sequence hands its sums over and starts from zero
        full_acc_q <= s1_q.last ? '0 : full_sat;
        core_acc_q <= s1_q.last ? '0 : core_sat;
      end
      if (s1_adv && s1_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    if (s1_adv && s1_q.last) begin
      out_q <= '{total_score: full_sat, window_score: core_sat, status: s1_q.status};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/pwmlls_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmlls_checker
// Port-level checks of the scorer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module pwmlls_checker
  import pwmlls_pkg::*;
#(
  parameter int unsigned MAX_MOTIF_LEN = MAX_MOTIF_LEN_DEF
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic in_fire, load_in_range, last_score;

  assign in_fire       = in_valid_i && in_ready_o;
  assign load_in_range = in_fire && (in_data_i.operation == OP_LOAD)
                       && (32'(in_data_i.column) < MAX_MOTIF_LEN);
  assign last_score    = in_fire && (in_data_i.operation == OP_SCORE)
                       && in_data_i.last_base;

  // a stalled result keeps its valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // no result right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // a table load occupies the log unit, so input closes the next cycle
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_in_range |=> !in_ready_o)
    else $error("input open while a load converts");

  // a fresh result always comes from an accepted final base via the read stage
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(last_score, 2))
    else $error("result without a final base");

endmodule

bind pwm_log_likelihood_scorer_core pwmlls_checker #(
  .MAX_MOTIF_LEN (MAX_MOTIF_LEN)
) u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
